FILE: hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by the front decoder, the command queue and the UTF-8 back end.
package jsu_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One queued command: up to two code points, then an optional tail result.
    // A single code point always sits in slot a.
    typedef struct packed {
        logic        a_en;
        logic [20:0] cp_a;
        logic        b_en;
        logic [20:0] cp_b;
        logic        tail_en;
        logic [7:0]  tail_byte;
        logic [1:0]  tail_kind;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

FILE: hdl/jsu_front.sv
// Front end: accepts string bytes, tracks escape and surrogate state,
// and turns each byte into at most one command. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_text_ended,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        M_PLAIN, M_ESC, M_HEX, M_HELD, M_HELD_ESC, M_HEX_LOW
    } t_mode;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] e);
        logic [7:0] r;
        r = e;
        case (e)
            8'h6E: r = 8'h0A;
            8'h74: r = 8'h09;
            8'h72: r = 8'h0D;
            8'h62: r = 8'h08;
            8'h66: r = 8'h0C;
            default: r = e;
        endcase
        return r;
    endfunction

    t_mode       r_mode, n_mode;
    logic [15:0] r_accum, n_accum;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_stopped, n_stopped;
    logic [15:0] r_held, n_held;

    logic        take;
    logic [4:0]  dig;
    logic [15:0] v;
    logic        v_low, v_high;
    t_cmd        cmd;
    logic        push;

    assign o_ready = !i_q_full;
    assign take    = i_valid && o_ready;
    assign dig     = hex_digit(i_text_byte);
    assign v       = (dig[4] && !r_stopped) ? {r_accum[11:0], dig[3:0]} : r_accum;
    assign v_low   = (v[15:10] == 6'b110111);
    assign v_high  = (v[15:10] == 6'b110110);

    always_comb begin
        n_mode    = r_mode;
        n_accum   = r_accum;
        n_cnt     = r_cnt;
        n_stopped = r_stopped;
        n_held    = r_held;
        cmd       = '0;
        push      = 1'b0;
        if (take) begin
            if (i_text_ended) begin
                cmd.tail_en   = 1'b1;
                cmd.tail_kind = KIND_ERROR;
                push      = 1'b1;
                n_mode    = M_PLAIN;
                n_accum   = '0;
                n_cnt     = '0;
                n_stopped = 1'b0;
                n_held    = '0;
            end else begin
                unique case (r_mode) inside
                    M_PLAIN: begin
                        if (i_text_byte == CH_QUOTE) begin
                            cmd.tail_en   = 1'b1;
                            cmd.tail_kind = KIND_CLOSE;
                            push   = 1'b1;
                            n_held = '0;
                        end else if (i_text_byte == CH_BSLASH) begin
                            n_mode = M_ESC;
                        end else begin
                            cmd.tail_en   = 1'b1;
                            cmd.tail_byte = i_text_byte;
                            push = 1'b1;
                        end
                    end
                    M_ESC: begin
                        if (i_text_byte == CH_U) begin
                            n_mode = M_HEX;
                        end else begin
                            cmd.tail_en   = 1'b1;
                            cmd.tail_byte = simple_escape(i_text_byte);
                            push   = 1'b1;
                            n_mode = M_PLAIN;
                        end
                    end
                    M_HELD: begin
                        if (i_text_byte == CH_BSLASH) begin
                            // hold the surrogate until the escape is known
                            n_mode = M_HELD_ESC;
                        end else begin
                            cmd.a_en    = 1'b1;
                            cmd.cp_a    = {5'd0, r_held};
                            cmd.tail_en = 1'b1;
                            push   = 1'b1;
                            n_mode = M_PLAIN;
                            if (i_text_byte == CH_QUOTE) begin
                                cmd.tail_kind = KIND_CLOSE;
                                n_held = '0;
                            end else begin
                                cmd.tail_byte = i_text_byte;
                            end
                        end
                    end
                    M_HELD_ESC: begin
                        if (i_text_byte == CH_U) begin
                            n_mode = M_HEX_LOW;
                        end else begin
                            cmd.a_en      = 1'b1;
                            cmd.cp_a      = {5'd0, r_held};
                            cmd.tail_en   = 1'b1;
                            cmd.tail_byte = simple_escape(i_text_byte);
                            push   = 1'b1;
                            n_held = '0;
                            n_mode = M_PLAIN;
                        end
                    end
                    M_HEX, M_HEX_LOW: begin
                        n_stopped = r_stopped | !dig[4];
                        n_accum   = v;
                        n_cnt     = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            n_accum   = '0;
                            n_cnt     = '0;
                            n_stopped = 1'b0;
                            if (r_mode == M_HEX_LOW && v_low) begin
                                // combine pair: 0x10000 + (hi - 0xD800) << 10 + (lo - 0xDC00)
                                cmd.a_en = 1'b1;
                                cmd.cp_a = {1'b0, r_held[9:0], v[9:0]} + 21'h10000;
                                push   = 1'b1;
                                n_held = '0;
                                n_mode = M_PLAIN;
                            end else begin
                                if (r_mode == M_HEX_LOW) begin
                                    cmd.a_en = 1'b1;
                                    cmd.cp_a = {5'd0, r_held};
                                    push = 1'b1;
                                end
                                if (v_high) begin
                                    n_held = v;
                                    n_mode = M_HELD;
                                end else begin
                                    n_held = '0;
                                    n_mode = M_PLAIN;
                                    push   = 1'b1;
                                    if (r_mode == M_HEX_LOW) begin
                                        cmd.b_en = 1'b1;
                                        cmd.cp_b = {5'd0, v};
                                    end else begin
                                        cmd.a_en = 1'b1;
                                        cmd.cp_a = {5'd0, v};
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        n_mode    = M_PLAIN;
                        n_accum   = '0;
                        n_cnt     = '0;
                        n_stopped = 1'b0;
                        n_held    = '0;
                    end
                endcase
            end
        end
    end

    assign o_push = push;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_PLAIN;
            r_accum   <= '0;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
            r_held    <= '0;
        end else begin
            r_mode    <= n_mode;
            r_accum   <= n_accum;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
            r_held    <= n_held;
        end
    end

    a_hex_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != M_HEX && r_mode != M_HEX_LOW)
            |-> (r_cnt == 2'd0 && !r_stopped && r_accum == 16'd0))
        else $error("hex state not clear outside hex mode");

    a_held_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HELD || r_mode == M_HELD_ESC || r_mode == M_HEX_LOW)
            |-> (r_held[15:10] == 6'b110110))
        else $error("held value is not a high surrogate");

endmodule

FILE: hdl/jsu_queue.sv
// Short command queue between front decoder and UTF-8 back end.
// Register array with head read in place. Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= wrap_inc(r_wr);
            if (i_pop)  r_rd <= wrap_inc(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_stat.full) |-> i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

FILE: hdl/jsu_back.sv
// Back end: expands the queue head into result items, one per cycle unless
// stalled, via a UTF-8 encoder into an output register. Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_stat    i_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    typedef enum logic [1:0] {S_A, S_B, S_TAIL} t_slot;

    // index of the final UTF-8 byte, 0..3
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp[20:7] == '0)       r = 2'd0;
        else if (cp[20:11] == '0) r = 2'd1;
        else if (cp[20:16] == '0) r = 2'd2;
        else                      r = 2'd3;
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                             input logic [1:0] idx);
        logic [7:0] r;
        r = '0;
        unique case (last)
            2'd0: r = cp[7:0];
            2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2: begin
                unique case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

    t_slot       r_slot;
    logic [1:0]  r_idx;
    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    logic [1:0]  r_o_kind;
    logic        r_o_last;

    t_slot       slot, next_slot;
    logic [20:0] cp;
    logic [1:0]  len_last;
    logic [7:0]  cur_byte;
    logic [1:0]  cur_kind;
    logic        slot_end, final_res, emit;

    always_comb begin
        slot      = (r_slot == S_A && !i_head.a_en) ? S_TAIL : r_slot;
        cp        = (slot == S_B) ? i_head.cp_b : i_head.cp_a;
        len_last  = utf8_last_idx(cp);
        next_slot = S_TAIL;
        final_res = 1'b0;
        if (slot == S_TAIL) begin
            cur_byte  = i_head.tail_byte;
            cur_kind  = i_head.tail_kind;
            slot_end  = 1'b1;
            final_res = 1'b1;
        end else begin
            cur_byte = utf8_byte(cp, len_last, r_idx);
            cur_kind = KIND_BYTE;
            slot_end = (r_idx == len_last);
            if (slot == S_A && i_head.b_en) next_slot = S_B;
            final_res = slot_end && !i_head.tail_en && next_slot != S_B;
        end
    end

    assign emit  = !i_stat.empty && (!r_o_valid || i_ready);
    assign o_pop = emit && final_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_slot    <= S_A;
            r_idx     <= '0;
        end else begin
            if (emit) begin
                r_o_valid <= 1'b1;
                r_o_byte  <= cur_byte;
                r_o_kind  <= cur_kind;
                r_o_last  <= final_res;
                // advance through the head; drop it after its final result
                if (final_res) begin
                    r_slot <= S_A;
                    r_idx  <= '0;
                end else if (slot_end) begin
                    r_slot <= next_slot;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_byte = r_o_byte;
    assign o_kind     = r_o_kind;
    assign o_last     = r_o_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_stat.empty && slot != S_TAIL) |-> (r_idx <= len_last))
        else $error("UTF-8 byte index past end of sequence");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind != KIND_BYTE) |-> r_o_last)
        else $error("close or error result not marked last");

    a_slot_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot == S_B) |-> (!i_stat.empty && i_head.b_en))
        else $error("second code point slot without a command");

endmodule

FILE: hdl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_text_byte, i_text_ended
//   result   out        o_valid / i_ready    o_out_byte, o_kind, o_last
//
// The front decodes one input byte per cycle; its own state is the only loop.
// The back sends one result per cycle unless the output stalls, so an item
// with up to 6 results holds the back; the queue absorbs such bursts.
// Input is refused only while the queue is full; output stall backs up there.
// Reset is synchronous; no clearing pass.
module json_string_unescape_utf8 import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_text_ended,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic    push, pop;
    t_cmd    cmd, head;
    t_q_stat stat;

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_text_byte  (i_text_byte),
        .i_text_ended (i_text_ended),
        .i_q_full     (stat.full),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_stat     (stat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

endmodule
